### hdl/zpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zpe_pkg: shared types, constants and tables of the Zernike evaluator
// Item structs, CORDIC arctangent table, radial coefficient lookup.
// ----------------------------------------------------------------------------
package zpe_pkg;

   // fixed-point formats
   localparam int RADIUS_FRAC_BITS = 15;
   localparam int ANGLE_BITS       = 16;
   localparam int OUT_FRAC_BITS    = 14;

   localparam logic [31:0] RAD_ONE     = 32'd1 << RADIUS_FRAC_BITS;
   localparam int          RAD_SHIFT   = 30 - RADIUS_FRAC_BITS;
   localparam logic [31:0] ANGLE_MASK  = (32'd1 << ANGLE_BITS) - 32'd1;
   localparam int          ANGLE_SHIFT = 32 - ANGLE_BITS;

   localparam int                 OUT_SHIFT  = 60 - OUT_FRAC_BITS;
   localparam logic signed [63:0] OUT_HALF   = 64'sd1 <<< (59 - OUT_FRAC_BITS);
   localparam logic signed [18:0] OUT_LIM    = 19'sd1 <<< OUT_FRAC_BITS;
   localparam logic signed [15:0] OUT_LIM16  = 16'sd1 <<< OUT_FRAC_BITS;

   // CORDIC chain
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
   localparam int CW           = 33;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [CW-1:0] QUARTER_TURN = 33'sd1073741824;
   localparam logic signed [CW-1:0] HALF_TURN    = 33'sd2147483648;

   localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
      30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
   };

   // radial pipeline: four power stages plus a final sum stage
   localparam int RAD_MUL_STAGES = 4;
   localparam int RAD_STAGES     = RAD_MUL_STAGES + 1;
   localparam int RAD_DELAY      = CORDIC_STEPS - RAD_STAGES;

   // accept to result strobe: front stage, chain, multiply, round
   localparam int LATENCY = CORDIC_STEPS + 3;

   // register indexes
   localparam logic [0:0] CSR_ORDER_N      = 1'b0;
   localparam logic [0:0] CSR_REPETITION_M = 1'b1;

   typedef struct packed {
      logic [15:0] radius;
      logic [15:0] angle_turns;
   } req_type;

   typedef struct packed {
      logic signed [15:0] real_part;
      logic signed [15:0] imag_part;
      logic               unsupported_order;
   } rsp_type;

   typedef logic signed [4:0]  coef_type;
   typedef coef_type    [5:0]  coef_row_type;

   typedef struct packed {
      logic         unsup;
      coef_row_type coef;
   } radial_sel_type;

   typedef struct packed {
      logic                valid;
      logic                flip;
      logic                unsup;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cell_type;

   typedef struct packed {
      logic               valid;
      logic               unsup;
      logic signed [63:0] prod_re;
      logic signed [63:0] prod_im;
   } mul_type;

   // coefficients of R(n,k) on powers rho^0..rho^5
   function automatic radial_sel_type radial_lookup(input logic [2:0] n,
                                                    input logic [3:0] k);
      radial_sel_type sel;
      sel.unsup = 1'b0;
      sel.coef  = '0;
      unique case ({n, k})
         {3'd0, 4'd0}: sel.coef[0] = 5'sd1;
         {3'd1, 4'd1}: sel.coef[1] = 5'sd1;
         {3'd2, 4'd0}: begin
            sel.coef[0] = -5'sd1;
            sel.coef[2] = 5'sd2;
         end
         {3'd2, 4'd2}: sel.coef[2] = 5'sd1;
         {3'd3, 4'd1}: begin
            sel.coef[1] = -5'sd2;
            sel.coef[3] = 5'sd3;
         end
         {3'd3, 4'd3}: sel.coef[3] = 5'sd1;
         {3'd4, 4'd0}: begin
            sel.coef[0] = 5'sd1;
            sel.coef[2] = -5'sd6;
            sel.coef[4] = 5'sd6;
         end
         {3'd4, 4'd2}: begin
            sel.coef[2] = -5'sd3;
            sel.coef[4] = 5'sd4;
         end
         {3'd4, 4'd4}: sel.coef[4] = 5'sd1;
         {3'd5, 4'd1}: begin
            sel.coef[1] = 5'sd3;
            sel.coef[3] = -5'sd12;
            sel.coef[5] = 5'sd10;
         end
         {3'd5, 4'd3}: begin
            sel.coef[3] = -5'sd4;
            sel.coef[5] = 5'sd5;
         end
         {3'd5, 4'd5}: sel.coef[5] = 5'sd1;
         default:      sel.unsup = 1'b1;
      endcase
      return sel;
   endfunction

endpackage
`default_nettype wire

### hdl/zpe_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zpe_cell: one CORDIC rotation cell
// Applies one micro-rotation and hands the item to the next cell.
// ----------------------------------------------------------------------------
module zpe_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [zpe_pkg::STEP_IDX_W-1:0] shift_amt,
   input  wire logic [29:0]                 atan_val,
   input  wire zpe_pkg::cell_type           prev_data,
   output      zpe_pkg::cell_type           next_data
);
   import zpe_pkg::*;

   cell_type stage_ff, stage_in;
   logic signed [CW-1:0] dx, dy, da;

   always_comb begin
      dx = prev_data.y >>> shift_amt;
      dy = prev_data.x >>> shift_amt;
      da = $signed({3'b000, atan_val});
      stage_in = prev_data;
      if (!prev_data.z[CW-1]) begin
         stage_in.x = prev_data.x - dx;
         stage_in.y = prev_data.y + dy;
         stage_in.z = prev_data.z - da;
      end else begin
         stage_in.x = prev_data.x + dx;
         stage_in.y = prev_data.y - dy;
         stage_in.z = prev_data.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign next_data = stage_ff;

endmodule
`default_nettype wire

### hdl/zpe_radial.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zpe_radial: radial polynomial pipeline
// Powers of rho in Q.30, one product per stage, summed with the row
// coefficients, then delayed to line up with the CORDIC chain.
// ----------------------------------------------------------------------------
module zpe_radial (
   input  wire logic                  clock,
   input  wire logic [30:0]           r_in,
   input  wire zpe_pkg::coef_row_type coef_in,
   output      logic signed [31:0]    rval_out
);
   import zpe_pkg::*;

   localparam logic [61:0] RND = 62'd1 << 29;

   logic [30:0]        r_s    [RAD_MUL_STAGES+1];
   logic [30:0]        pw_s   [RAD_MUL_STAGES+1];
   logic signed [36:0] acc_s  [RAD_MUL_STAGES+1];
   coef_row_type       coef_s [RAD_MUL_STAGES+1];

   assign r_s[0]    = r_in;
   assign pw_s[0]   = r_in;
   assign coef_s[0] = coef_in;
   assign acc_s[0]  = {{2{coef_in[0][4]}}, coef_in[0], 30'b0};

   // stage j: next power and the term of power j
   for (genvar j = 1; j <= RAD_MUL_STAGES; j++) begin : g_pow
      logic [61:0]        prod;
      logic signed [36:0] term;
      logic [30:0]        r_ff, pw_ff, pw_in;
      logic signed [36:0] acc_ff, acc_in;
      coef_row_type       coef_ff;

      assign prod   = 62'(pw_s[j-1]) * 62'(r_s[j-1]);
      assign pw_in  = 31'((prod + RND) >> 30);
      assign term   = 37'($signed(coef_s[j-1][j])) * 37'($signed({1'b0, pw_s[j-1]}));
      assign acc_in = acc_s[j-1] + term;

      always_ff @(posedge clock) begin
         r_ff    <= r_s[j-1];
         pw_ff   <= pw_in;
         acc_ff  <= acc_in;
         coef_ff <= coef_s[j-1];
      end

      assign r_s[j]    = r_ff;
      assign pw_s[j]   = pw_ff;
      assign acc_s[j]  = acc_ff;
      assign coef_s[j] = coef_ff;
   end

   // last term; the true sum stays within 32 signed bits
   logic signed [36:0] last_term, sum_full;
   logic signed [31:0] rval_ff, rval_in;

   assign last_term = 37'($signed(coef_s[RAD_MUL_STAGES][RAD_MUL_STAGES+1]))
                      * 37'($signed({1'b0, pw_s[RAD_MUL_STAGES]}));
   assign sum_full  = acc_s[RAD_MUL_STAGES] + last_term;
   assign rval_in   = $signed(sum_full[31:0]);

   always_ff @(posedge clock) begin
      rval_ff <= rval_in;
   end

   // alignment delay
   logic signed [31:0] dly_ff [RAD_DELAY];

   always_ff @(posedge clock) begin
      dly_ff[0] <= rval_ff;
      for (int d = 1; d < RAD_DELAY; d++) begin
         dly_ff[d] <= dly_ff[d-1];
      end
   end

   assign rval_out = dly_ff[RAD_DELAY-1];

endmodule
`default_nettype wire

### hdl/zernike_polynomial_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zernike_polynomial_evaluator: complex Zernike polynomial V(n,m)
// Per item: V = R(n,|m|)(rho) * exp(i*m*phi), real and imaginary in Q2.14.
// ----------------------------------------------------------------------------
// Usage
//   Config: csr_we/csr_addr/csr_data write order_n (index 0) and
//   repetition_m (index 1). Write only while no item is in flight.
//   Input: an item (radius Q1.15, angle in 1/65536 turn) is taken at a
//   rising edge with start high and busy low.
//   Output: rsp_valid strobes for one cycle with rsp_data. The receiver
//   cannot stall; every item gives exactly one result.
// Timing
//   Path: from the accept edge to the strobe an item passes the front
//   stage, 24 CORDIC cells, the multiply stage and the round/clamp stage.
//   Throughput: one item per cycle while busy is low, set by the 24-cell
//   rotation chain that moves one item per cell per cycle; the radial
//   products run in a parallel 5-stage pipeline.
// Reset
//   Synchronous, active high. Clears both registers (n = 0, m = 0) and
//   all valid bits; busy is high for the cycle after reset.
//   Unsupported (n,m) pairs return zero and set unsupported_order.
// ----------------------------------------------------------------------------
module zernike_polynomial_evaluator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire zpe_pkg::req_type req_data,
   output      logic             rsp_valid,
   output      zpe_pkg::rsp_type rsp_data,
   input  wire logic             csr_we,
   input  wire logic [0:0]       csr_addr,
   input  wire logic [3:0]       csr_data
);
   import zpe_pkg::*;

   // configuration registers
   logic [2:0] order_n_ff;
   logic [3:0] rep_m_ff;
   logic       busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_n_ff <= '0;
         rep_m_ff   <= '0;
         busy_ff    <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_ORDER_N:      order_n_ff <= csr_data[2:0];
               CSR_REPETITION_M: rep_m_ff   <= csr_data;
            endcase
         end
      end
   end

   assign busy = busy_ff;

   // front stage: clamp radius, form phase, fold to +-quarter turn,
   // pick coefficient row
   cell_type       front_ff, front_in;
   logic [30:0]    r_ff, r_in;
   coef_row_type   coef_ff;
   radial_sel_type sel;
   logic [31:0]    rad_clamped, ang_t, m_ext, phase;
   logic [3:0]     k_abs;
   logic signed [31:0]   z_raw;
   logic signed [CW-1:0] z_ext;

   always_comb begin
      rad_clamped = (32'(req_data.radius) > RAD_ONE) ? RAD_ONE : 32'(req_data.radius);
      r_in        = 31'(rad_clamped << RAD_SHIFT);
      ang_t       = (32'(req_data.angle_turns) & ANGLE_MASK) << ANGLE_SHIFT;
      m_ext       = {{28{rep_m_ff[3]}}, rep_m_ff};
      phase       = m_ext * ang_t;          // modulo one turn
      z_raw       = $signed(phase);
      z_ext       = CW'(z_raw);
      k_abs       = rep_m_ff[3] ? 4'(-rep_m_ff) : rep_m_ff;
      sel         = radial_lookup(order_n_ff, k_abs);

      front_in.valid = start && !busy_ff;
      front_in.unsup = sel.unsup;
      front_in.x     = CORDIC_GAIN;
      front_in.y     = '0;
      if (z_ext > QUARTER_TURN) begin
         front_in.z    = z_ext - HALF_TURN;
         front_in.flip = 1'b1;
      end else if (z_ext < -QUARTER_TURN) begin
         front_in.z    = z_ext + HALF_TURN;
         front_in.flip = 1'b1;
      end else begin
         front_in.z    = z_ext;
         front_in.flip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      coef_ff <= sel.coef;
      if (reset) begin
         front_ff <= '0;
      end else begin
         front_ff <= front_in;
      end
   end

   // rotation chain
   cell_type chain [CORDIC_STEPS+1];

   assign chain[0] = front_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      zpe_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (STEP_IDX_W'(g)),
         .atan_val  (ATAN_TURNS[g]),
         .prev_data (chain[g]),
         .next_data (chain[g+1])
      );
   end

   // radial part, arrives together with the chain output
   logic signed [31:0] rval;

   zpe_radial u_radial (
      .clock    (clock),
      .r_in     (r_ff),
      .coef_in  (coef_ff),
      .rval_out (rval)
   );

   // multiply stage; half-turn fold undone by negating cos/sin
   cell_type             chain_out;
   logic signed [CW-1:0] x_neg, y_neg;
   logic signed [31:0]   x_sel, y_sel;
   mul_type              mul_ff, mul_in;

   always_comb begin
      chain_out = chain[CORDIC_STEPS];
      x_neg     = -chain_out.x;
      y_neg     = -chain_out.y;
      x_sel     = chain_out.flip ? $signed(x_neg[31:0]) : $signed(chain_out.x[31:0]);
      y_sel     = chain_out.flip ? $signed(y_neg[31:0]) : $signed(chain_out.y[31:0]);
      mul_in.valid   = chain_out.valid;
      mul_in.unsup   = chain_out.unsup;
      mul_in.prod_re = 64'(rval) * 64'(x_sel);
      mul_in.prod_im = 64'(rval) * 64'(y_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= '0;
      end else begin
         mul_ff <= mul_in;
      end
   end

   // round to Q.14 and clamp to +-1.0
   function automatic logic signed [15:0] sat_out(input logic signed [63:0] prod);
      logic signed [63:0] sum;
      logic signed [18:0] v;
      logic signed [18:0] c;
      sum = prod + OUT_HALF;
      v   = 19'(sum >>> OUT_SHIFT);
      if (v > OUT_LIM) begin
         c = OUT_LIM;
      end else if (v < -OUT_LIM) begin
         c = -OUT_LIM;
      end else begin
         c = v;
      end
      return $signed(c[15:0]);
   endfunction

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in                  = mul_ff.valid;
      rsp_data_in.unsupported_order = mul_ff.unsup;
      if (mul_ff.unsup) begin
         rsp_data_in.real_part = '0;
         rsp_data_in.imag_part = '0;
      end else begin
         rsp_data_in.real_part = sat_out(mul_ff.prod_re);
         rsp_data_in.imag_part = sat_out(mul_ff.prod_im);
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_ready_after_reset: assert property (@(posedge clock) !reset |=> !busy)
      else $error("busy still high after reset released");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item did not produce a result on time");

   a_unsup_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.unsupported_order) |->
         (rsp_data.real_part == '0 && rsp_data.imag_part == '0))
      else $error("unsupported pair returned nonzero result");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.real_part <= OUT_LIM16 && rsp_data.real_part >= -OUT_LIM16
                  && rsp_data.imag_part <= OUT_LIM16 && rsp_data.imag_part >= -OUT_LIM16))
      else $error("result beyond unit magnitude");

endmodule
`default_nettype wire

### sim/zernike_polynomial_evaluator_test.sv
// ----------------------------------------------------------------------------
// zernike_polynomial_evaluator_test: self-checking bench for the evaluator
// Drives pixel items (radius, angle) under many (n,m) settings and compares
// every result with a bit-exact fixed-point model of V(n,m) kept here.
// ----------------------------------------------------------------------------
module zernike_polynomial_evaluator_test;
   import zpe_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PIXELS = 1600;
   localparam longint Q14_ONE   = 64'sd1 <<< 14;
   localparam longint ROT_GAIN  = 64'sd652032874;
   localparam longint QTR_TURN  = 64'sd1 <<< 30;
   localparam longint HALF_TURN = 64'sd1 <<< 31;

   // arctangent of 2^-i in 2^32-per-turn units
   localparam longint ROT_ANGLE [24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
   };

   typedef struct {
      req_type item;
      int      gap_after;   // idle cycles the sender leaves after this item
   } pixel_entry_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    start     = 1'b0;
   logic    busy;
   req_type req_data  = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic       csr_we   = 1'b0;
   logic [0:0] csr_addr = '0;
   logic [3:0] csr_data = '0;

   pixel_entry_type pixel_q[$];      // items waiting for the driver
   rsp_type         expected_v_q[$]; // predicted V for items in flight

   // local copy of the two registers
   logic [2:0]        cfg_order = '0;
   logic signed [3:0] cfg_rep   = '0;

   bit item_taken;
   int idle_left;
   int cycle_count;
   int error_count;
   int results_checked;
   int unsupported_seen;
   int settings_used;

   zernike_polynomial_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round Q.60 product to Q2.14 and clamp to +-1.0
   function automatic logic signed [15:0] round_q14(input longint prod);
      longint v;
      v = (prod + (64'sd1 <<< 45)) >>> 46;
      if (v > Q14_ONE) v = Q14_ONE;
      else if (v < -Q14_ONE) v = -Q14_ONE;
      return 16'(v);
   endfunction

   // V(n,m) = R(n,|m|)(rho) * exp(i*m*phi), bit exact
   function automatic rsp_type zernike_value(input logic [2:0] n,
                                             input logic signed [3:0] m,
                                             input req_type pix);
      rsp_type           res;
      int                mi;
      int                k;
      longint            c [6];
      bit                known;
      longint unsigned   rad;
      longint unsigned   r;
      longint unsigned   p;
      longint            rval;
      longint            x;
      longint            y;
      longint            z;
      longint            dx;
      longint            dy;
      logic [31:0]       t;
      logic [31:0]       ph;
      bit                flip;
      res   = '0;
      mi    = int'(m);
      k     = (mi < 0) ? -mi : mi;
      known = 1'b1;
      // radial coefficients on rho^0..rho^5, keyed by 10*n + |m|
      case (10 * int'(n) + k)
         0:  c = '{1, 0, 0, 0, 0, 0};
         11: c = '{0, 1, 0, 0, 0, 0};
         20: c = '{-1, 0, 2, 0, 0, 0};
         22: c = '{0, 0, 1, 0, 0, 0};
         31: c = '{0, -2, 0, 3, 0, 0};
         33: c = '{0, 0, 0, 1, 0, 0};
         40: c = '{1, 0, -6, 0, 6, 0};
         42: c = '{0, 0, -3, 0, 4, 0};
         44: c = '{0, 0, 0, 0, 1, 0};
         51: c = '{0, 3, 0, -12, 0, 10};
         53: c = '{0, 0, 0, -4, 0, 5};
         55: c = '{0, 0, 0, 0, 0, 1};
         default: known = 1'b0;
      endcase
      if (!known) begin
         res.unsupported_order = 1'b1;
         return res;
      end

      // radial part, Q.30; radius above one saturates
      rad = 64'(pix.radius);
      if (rad > 64'd32768) rad = 64'd32768;
      r    = rad << 15;
      p    = 64'd1 << 30;
      rval = 0;
      for (int i = 0; i < 6; i++) begin
         rval += c[i] * longint'(p);
         p = (p * r + (64'd1 << 29)) >> 30;
      end

      // phase m*phi modulo one turn, folded into +-quarter turn
      t    = {pix.angle_turns, 16'h0000};
      ph   = 32'(mi) * t;
      z    = longint'($signed(ph));
      flip = 1'b0;
      if (z > QTR_TURN) begin
         z    -= HALF_TURN;
         flip  = 1'b1;
      end else if (z < -QTR_TURN) begin
         z    += HALF_TURN;
         flip  = 1'b1;
      end

      x = ROT_GAIN;
      y = 0;
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ROT_ANGLE[i];
         end else begin
            x += dx;
            y -= dy;
            z += ROT_ANGLE[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end

      res.real_part = round_q14(rval * x);
      res.imag_part = round_q14(rval * y);
      return res;
   endfunction

   // Rising edge: check a result first, then record an accepted item and
   // any register write. Checking before pushing keeps an item accepted at
   // this edge from being matched against a stray result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_v_q.size());
         $display("zernike_polynomial_evaluator test failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_v_q.size() == 0) begin
               $error("result with no item in flight");
               error_count++;
            end else begin
               rsp_type want;
               want = expected_v_q.pop_front();
               if (rsp_data.real_part !== want.real_part) begin
                  $error("real_part: expected %0d, actual %0d",
                         want.real_part, rsp_data.real_part);
                  error_count++;
               end
               if (rsp_data.imag_part !== want.imag_part) begin
                  $error("imag_part: expected %0d, actual %0d",
                         want.imag_part, rsp_data.imag_part);
                  error_count++;
               end
               if (rsp_data.unsupported_order !== want.unsupported_order) begin
                  $error("unsupported_order: expected %0b, actual %0b",
                         want.unsupported_order, rsp_data.unsupported_order);
                  error_count++;
               end
               if (want.unsupported_order) unsupported_seen++;
               results_checked++;
            end
         end

         item_taken = start && (busy === 1'b0);
         if (item_taken)
            expected_v_q.push_back(zernike_value(cfg_order, cfg_rep, req_data));

         if (csr_we) begin
            if (csr_addr == CSR_ORDER_N) cfg_order = csr_data[2:0];
            else                         cfg_rep   = csr_data;
         end
      end
   end

   // Driver: falling edge. Holds an item while busy, then leaves the
   // drawn number of idle cycles before presenting the next one.
   always @(negedge clock) begin
      pixel_entry_type head;
      if (!reset && (!start || item_taken)) begin
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
         end else if (pixel_q.size() != 0) begin
            head      = pixel_q.pop_front();
            req_data  <= head.item;
            start     <= 1'b1;
            idle_left <= head.gap_after;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic queue_pixel(input logic [15:0] radius, input logic [15:0] angle,
                              input int gap);
      pixel_entry_type e;
      e.item.radius      = radius;
      e.item.angle_turns = angle;
      e.gap_after        = gap;
      pixel_q.push_back(e);
   endtask

   // sender pause: nothing queued, nothing presented, nothing in flight
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_q.size() != 0 || start || expected_v_q.size() != 0);
   endtask

   // n_word carries a spare top bit that the block must drop
   task automatic set_order(input logic [3:0] n_word, input logic signed [3:0] m_word);
      wait_drained();
      csr_we   <= 1'b1;
      csr_addr <= CSR_ORDER_N;
      csr_data <= n_word;
      @(negedge clock);
      csr_addr <= CSR_REPETITION_M;
      csr_data <= m_word;
      @(negedge clock);
      csr_we   <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int          queued;
      int          burst;
      int          n;
      int          k;
      int          m;
      bit          gappy;
      logic [15:0] rad;
      logic [15:0] ang;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset values n = 0, m = 0; over-range radius saturates
      queue_pixel(16'd0, 16'd0, 0);
      queue_pixel(16'hFFFF, 16'hFFFF, 3);

      // highest order, both rotation directions, radius and angle extremes
      set_order(4'd5, 4'sd5);
      queue_pixel(16'd32768, 16'd0, 0);
      queue_pixel(16'hFFFF, 16'hFFFF, 0);
      queue_pixel(16'd32769, 16'd16384, 1);
      queue_pixel(16'd0, 16'd32768, 0);
      set_order(4'd5, -4'sd5);
      queue_pixel(16'd32768, 16'd16384, 0);
      queue_pixel(16'd12345, 16'd49152, 2);

      // phase landing exactly on a quarter turn, just past it, three quarters, a half turn
      set_order(4'd1, 4'sd1);
      queue_pixel(16'd32768, 16'd16384, 0);
      queue_pixel(16'd32768, 16'd16385, 0);
      queue_pixel(16'd32768, 16'd49152, 0);
      queue_pixel(16'd32768, 16'd32768, 0);
      set_order(4'd1, -4'sd1);
      queue_pixel(16'd32768, 16'd16384, 0);

      // rotation-free order with large interior coefficients
      set_order(4'd4, 4'sd0);
      queue_pixel(16'd16384, 16'd1000, 0);
      queue_pixel(16'd23170, 16'd60000, 0);

      // unsupported pairs: odd n - |m|, |m| > n, n > 5, extreme codes
      set_order(4'd3, 4'sd2);
      queue_pixel(16'd20000, 16'd20000, 0);
      set_order(4'd2, -4'sd4);
      queue_pixel(16'd32768, 16'd1, 0);
      set_order(4'd6, 4'sd0);
      queue_pixel(16'd32768, 16'd0, 0);
      set_order(4'b1111, -4'sd8);
      queue_pixel(16'd100, 16'd200, 0);
      // top bit of the order word is ignored: n = 4, m = 7 unsupported
      set_order(4'b1100, 4'sd7);
      queue_pixel(16'd32768, 16'd40000, 0);

      // --- random ---
      // Mostly supported pairs; about one setting in five is any code at all.
      queued = 0;
      while (queued < RANDOM_PIXELS) begin
         if ($urandom_range(0, 4) != 0) begin
            n = $urandom_range(0, 5);
            k = n - 2 * $urandom_range(0, n / 2);
            m = $urandom_range(0, 1) ? -k : k;
         end else begin
            n = $urandom_range(0, 7);
            m = $urandom_range(0, 15);
         end
         set_order({1'($urandom_range(0, 1)), 3'(n)}, 4'(m));

         // some bursts run back to back, the rest with random gaps
         gappy = ($urandom_range(0, 3) != 0);
         burst = $urandom_range(10, 60);
         for (int i = 0; i < burst; i++) begin
            case ($urandom_range(0, 9))
               0:       rad = 16'd0;
               1:       rad = 16'd32768;
               2:       rad = 16'($urandom_range(32769, 65535));
               default: rad = 16'($urandom_range(0, 32768));
            endcase
            // cluster some angles around quadrant boundaries
            if ($urandom_range(0, 4) == 0)
               ang = {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
            else
               ang = 16'($urandom_range(0, 65535));
            queue_pixel(rad, ang, gappy ? $urandom_range(0, 8) : 0);
         end
         queued += burst;
      end

      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);

      $display("checked %0d results across %0d (n,m) settings", results_checked,
               settings_used + 1);
      $display("%0d results flagged unsupported, %0d mismatches", unsupported_seen,
               error_count);
      if (error_count == 0)
         $display("zernike_polynomial_evaluator test passed");
      else
         $display("zernike_polynomial_evaluator test failed");
      $finish;
   end

endmodule

### files.f
hdl/zpe_pkg.sv
hdl/zpe_cell.sv
hdl/zpe_radial.sv
hdl/zernike_polynomial_evaluator.sv
sim/zernike_polynomial_evaluator_test.sv
